@@ rtl/core/hfmtw_pkg.sv @@
// shared types and constants for the huffman tree-walk decoder
package hfmtw_pkg;

  localparam int NODE_W     = 9;
  localparam int CHILD_W    = 10;
  localparam int BYTE_W     = 8;
  localparam int BIT_CNT_W  = 4;
  localparam int TOTAL_W    = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [NODE_W-1:0]  ROOT_RESET = 9'd510;
  localparam logic [CHILD_W-1:0] CHILD_NONE = 10'h3FF;
  localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_DECODE  = 2'd1,
    OP_RESTART = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROOT  = 2'd0,
    REG_TOTAL = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_STEP,
    ST_CHECK,
    ST_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic [CHILD_W-1:0] left;
    logic [CHILD_W-1:0] right;
  } node_entry_t;

  typedef struct packed {
    logic clear;
    logic inc;
  } cnt_ctrl_t;

  typedef struct packed {
    logic ended;
    logic hit;
  } cnt_stat_t;

endpackage

@@ rtl/core/huffman_tree_walk_decoder_top.sv @@
// huffman tree-walk decoder: configuration registers, node memory, counter and walk sequencer
// load, restart and unused items are handled in idle, so the block stays ready for the next item.
// a decode item walks its bits one at a time through one memory read port: per bit, test reads
// the cursor node, step takes the child and reads it, check tests it for a leaf; an invalid child
// or an out-of-range cursor sends the walk back to root; flush ends the byte once output is free;
// a symbol is held until the next one or the end of its byte decides its last flag.
// synchronous reset clears the counter, sets root and cursor to 510, total to zero; nodes undefined
module huffman_tree_walk_decoder_top
  import hfmtw_pkg::*;
#(
  parameter int NODE_COUNT  = 511,
  parameter int COUNT_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            opcode,
  input  logic [NODE_W-1:0]     node_index,
  input  logic signed [CHILD_W-1:0] left_index,
  input  logic signed [CHILD_W-1:0] right_index,
  input  logic [BYTE_W-1:0]     code_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [BYTE_W-1:0]     symbol,
  output logic                  last,
  output logic                  stream_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [NODE_W-1:0]  root_node;
  logic [TOTAL_W-1:0] symbol_total;

  logic        wr_en;
  node_entry_t wr_entry;
  logic        rd_en;
  logic [NODE_W-1:0] rd_addr;
  node_entry_t rd_entry;
  cnt_ctrl_t   cnt_ctrl;
  cnt_stat_t   cnt_stat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node    <= ROOT_RESET;
      symbol_total <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROOT:  root_node    <= cfg_data[NODE_W-1:0];
        REG_TOTAL: symbol_total <= cfg_data[TOTAL_W-1:0];
        default:   root_node    <= root_node;
      endcase
    end
  end

  // loads beyond the table are dropped
  assign wr_en = in_valid && in_ready && (opcode == OP_LOAD) &&
                 (node_index < NODE_W'(NODE_COUNT));
  assign wr_entry.left  = left_index;
  assign wr_entry.right = right_index;

  hfmtw_node_mem #(
    .NODE_COUNT(NODE_COUNT)
  ) u_node_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (node_index),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_entry (rd_entry)
  );

  hfmtw_sym_count #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_sym_count (
    .clk   (clk),
    .rst   (rst),
    .ctrl  (cnt_ctrl),
    .total (symbol_total),
    .stat  (cnt_stat)
  );

  hfmtw_walk_ctrl #(
    .NODE_COUNT(NODE_COUNT)
  ) u_walk_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .code_byte   (code_byte),
    .root        (root_node),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_entry    (rd_entry),
    .cnt_ctrl    (cnt_ctrl),
    .cnt_stat    (cnt_stat),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .symbol      (symbol),
    .last        (last),
    .stream_done (stream_done)
  );

endmodule

@@ rtl/core/hfmtw_node_mem.sv @@
// tree node memory: one write port, one registered read port
module hfmtw_node_mem
  import hfmtw_pkg::*;
#(
  parameter int NODE_COUNT = 511
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [NODE_W-1:0]     wr_addr,
  input  node_entry_t           wr_entry,
  input  logic                  rd_en,
  input  logic [NODE_W-1:0]     rd_addr,
  output node_entry_t           rd_entry
);

  localparam int ADDR_W = $clog2(NODE_COUNT);

  node_entry_t mem [NODE_COUNT];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[ADDR_W-1:0]] <= wr_entry;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

endmodule

@@ rtl/core/hfmtw_sym_count.sv @@
// saturating symbol counter with end-of-stream compare
module hfmtw_sym_count
  import hfmtw_pkg::*;
#(
  parameter int COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  cnt_ctrl_t          ctrl,
  input  logic [TOTAL_W-1:0] total,
  output cnt_stat_t          stat
);

  localparam int CMP_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

  logic [COUNT_WIDTH-1:0] count;
  logic [COUNT_WIDTH-1:0] count_next;
  logic [COUNT_WIDTH-1:0] count_inc;

  always_comb begin
    count_inc = (count == '1) ? count : count + 1'b1;
    if (ctrl.clear) begin
      count_next = '0;
    end else if (ctrl.inc) begin
      count_next = count_inc;
    end else begin
      count_next = count;
    end
  end

  assign stat.ended = CMP_W'(count) >= CMP_W'(total);
  assign stat.hit   = CMP_W'(count_inc) == CMP_W'(total);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

@@ rtl/core/hfmtw_walk_ctrl.sv @@
// walk sequencer: one code bit at a time through the node memory, symbol buffering
module hfmtw_walk_ctrl
  import hfmtw_pkg::*;
#(
  parameter int NODE_COUNT = 511
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         opcode,
  input  logic [BYTE_W-1:0]  code_byte,
  input  logic [NODE_W-1:0]  root,
  output logic               rd_en,
  output logic [NODE_W-1:0]  rd_addr,
  input  node_entry_t        rd_entry,
  output cnt_ctrl_t          cnt_ctrl,
  input  cnt_stat_t          cnt_stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  symbol,
  output logic               last,
  output logic               stream_done
);

  walk_state_t state;
  walk_state_t state_next;

  logic [NODE_W-1:0]    cursor;
  logic [BYTE_W-1:0]    bits;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 pend_valid;
  logic [BYTE_W-1:0]    pend_sym;
  logic                 pend_done;

  logic               take;
  logic               start_decode;
  logic               restart;
  logic [CHILD_W-1:0] child_sel;
  logic               child_bad;
  logic               cursor_bad;
  logic               is_leaf;
  logic               out_free;
  logic               bits_left;
  logic               skip_bit;
  logic               emit;
  logic               pend_to_out;
  logic               consume_bit;

  assign take         = in_valid && in_ready;
  assign start_decode = take && (opcode == OP_DECODE);
  assign restart      = take && (opcode == OP_RESTART);
  assign child_sel    = bits[BYTE_W-1] ? rd_entry.right : rd_entry.left;
  assign child_bad    = child_sel[CHILD_W-1] ||
                        (child_sel[NODE_W-1:0] >= NODE_W'(NODE_COUNT));
  assign cursor_bad   = cursor >= NODE_W'(NODE_COUNT);
  assign is_leaf      = (rd_entry.left == CHILD_NONE) && (rd_entry.right == CHILD_NONE);
  assign out_free     = !out_valid || out_ready;
  assign bits_left    = !cnt_stat.ended && (bit_cnt != '0);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start_decode) begin
          state_next = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!bits_left) begin
          state_next = ST_FLUSH;
        end else if (!cursor_bad) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = child_bad ? ST_TEST : ST_CHECK;
      end
      ST_CHECK: begin
        if (!(is_leaf && pend_valid && !out_free)) begin
          state_next = ST_TEST;
        end
      end
      ST_FLUSH: begin
        if (!(pend_valid && !out_free)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    in_ready    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = cursor;
    skip_bit    = 1'b0;
    emit        = 1'b0;
    pend_to_out = 1'b0;
    consume_bit = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_TEST: begin
        if (bits_left && cursor_bad) begin
          skip_bit    = 1'b1;
          consume_bit = 1'b1;
        end else if (bits_left) begin
          rd_en = 1'b1;
        end
      end
      ST_STEP: begin
        consume_bit = 1'b1;
        rd_addr     = child_sel[NODE_W-1:0];
        rd_en       = !child_bad;
      end
      ST_CHECK: begin
        emit        = is_leaf && (!pend_valid || out_free);
        pend_to_out = emit && pend_valid;
      end
      ST_FLUSH: begin
        pend_to_out = pend_valid && out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign cnt_ctrl.clear = restart;
  assign cnt_ctrl.inc   = emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cursor     <= ROOT_RESET;
      bit_cnt    <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (restart || skip_bit || emit || (state == ST_STEP && child_bad)) begin
        cursor <= root;
      end else if (state == ST_STEP) begin
        cursor <= child_sel[NODE_W-1:0];
      end
      if (start_decode) begin
        bit_cnt <= BITS_PER_BYTE;
      end else if (consume_bit) begin
        bit_cnt <= bit_cnt - 1'b1;
      end
      if (emit) begin
        pend_valid <= 1'b1;
      end else if (pend_to_out) begin
        pend_valid <= 1'b0;
      end
      if (pend_to_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_decode) begin
      bits <= code_byte;
    end else if (consume_bit) begin
      bits <= {bits[BYTE_W-2:0], 1'b0};
    end
    if (emit) begin
      pend_sym  <= cursor[BYTE_W-1:0];
      pend_done <= cnt_stat.hit;
    end
    if (pend_to_out) begin
      symbol      <= pend_sym;
      stream_done <= pend_done;
      last        <= (state == ST_FLUSH);
    end
  end

  // a held symbol must be delivered before the block goes idle
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend_valid)
    else $error("symbol still held in idle");

  // a new leaf with a blocked output waits in place
  a_leaf_waits: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK && is_leaf && pend_valid && !out_free) |=> (state == ST_CHECK))
    else $error("leaf left before output slot freed");

  // a node entry is evaluated only after its read was issued
  a_step_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP || (state == ST_CHECK && $past(state) != ST_CHECK)) |-> $past(rd_en))
    else $error("node entry used without a read");

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the huffman tree-walk decoder with a symbol scoreboard
module testbench;
  import hfmtw_pkg::*;

  localparam int NODE_COUNT = 511;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;
  localparam int STUCK_LIMIT = 2000;
  localparam int PHASES = 5;
  localparam int ITEMS_PER_PHASE = 20;

  typedef struct packed {
    logic [BYTE_W-1:0] sym;
    logic              last_flag;
    logic              done_flag;
  } symbol_rec_t;

  // predicts decoded symbols and holds the ones not yet seen on the output
  class symbol_scoreboard;
    logic [CHILD_W-1:0] left_tab [NODE_COUNT];
    logic [CHILD_W-1:0] right_tab [NODE_COUNT];
    logic [NODE_W-1:0]  cursor;
    logic [NODE_W-1:0]  root;
    logic [TOTAL_W-1:0] count;
    logic [TOTAL_W-1:0] total;
    symbol_rec_t        symbols_q[$];
    int                 errors;

    function new();
      root = ROOT_RESET;
      total = '0;
      cursor = ROOT_RESET;
      count = '0;
      errors = 0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        left_tab[i] = '0;
        right_tab[i] = '0;
      end
    endfunction

    function int pending();
      return symbols_q.size();
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_ROOT) root = data[NODE_W-1:0];
      else if (idx == REG_TOTAL) total = data[TOTAL_W-1:0];
    endfunction

    function void note_input(logic [1:0] op, logic [NODE_W-1:0] node,
                             logic [CHILD_W-1:0] l, logic [CHILD_W-1:0] r,
                             logic [BYTE_W-1:0] code);
      symbol_rec_t row [8];
      logic [CHILD_W-1:0] child;
      int n;
      n = 0;
      if (op == OP_LOAD) begin
        if (node < NODE_COUNT) begin
          left_tab[node] = l;
          right_tab[node] = r;
        end
      end else if (op == OP_RESTART) begin
        cursor = root;
        count = '0;
      end else if (op == OP_DECODE) begin
        for (int b = 0; b < 8; b++) begin
          // stream ended: rest of the byte is dropped
          if (count >= total) break;
          if (cursor >= NODE_COUNT) begin
            cursor = root;
          end else begin
            child = code[7-b] ? right_tab[cursor] : left_tab[cursor];
            if (child[CHILD_W-1] || child >= NODE_COUNT) begin
              cursor = root;
            end else begin
              cursor = child[NODE_W-1:0];
              if (left_tab[child] == CHILD_NONE && right_tab[child] == CHILD_NONE) begin
                if (count != '1) count = count + 1'b1;
                row[n].sym = child[BYTE_W-1:0];
                row[n].last_flag = 1'b0;
                row[n].done_flag = (count == total);
                n++;
                cursor = root;
              end
            end
          end
        end
        if (n > 0) row[n-1].last_flag = 1'b1;
        for (int i = 0; i < n; i++) symbols_q.push_back(row[i]);
      end
    endfunction

    function void check_result(logic [BYTE_W-1:0] sym, logic last_flag, logic done_flag);
      symbol_rec_t want;
      if (symbols_q.size() == 0) begin
        $error("unexpected symbol %0d (last %0d, stream_done %0d)", sym, last_flag, done_flag);
        errors++;
        return;
      end
      want = symbols_q.pop_front();
      if (sym !== want.sym) begin
        $error("symbol: expected %0d, actual %0d", want.sym, sym);
        errors++;
      end
      if (last_flag !== want.last_flag) begin
        $error("last: expected %0d, actual %0d", want.last_flag, last_flag);
        errors++;
      end
      if (done_flag !== want.done_flag) begin
        $error("stream_done: expected %0d, actual %0d", want.done_flag, done_flag);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] opcode = OP_LOAD;
  logic [NODE_W-1:0] node_index = '0;
  logic signed [CHILD_W-1:0] left_index = '0;
  logic signed [CHILD_W-1:0] right_index = '0;
  logic [BYTE_W-1:0] code_byte = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BYTE_W-1:0] symbol;
  logic last;
  logic stream_done;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_reg_t cfg_index = REG_ROOT;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  symbol_scoreboard sb = new();
  bit idle_on = 1'b1;
  int stall_left = 0;
  int stuck = 0;

  // nodes loaded so far; random children point only at these or at no node
  bit written [NODE_COUNT];
  int written_q[$];

  huffman_tree_walk_decoder_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .node_index(node_index),
    .left_index(left_index),
    .right_index(right_index),
    .code_byte(code_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .symbol(symbol),
    .last(last),
    .stream_done(stream_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // output side: check each transfer, stall in bursts
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check_result(symbol, last, stream_done);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stuck <= 0;
    else
      stuck <= stuck + 1;
  end

  initial begin
    while (stuck < STUCK_LIMIT) @(posedge clk);
    $display("testbench: errors");
    $finish;
  end

  // valid stays high after a transfer unless a gap follows; callers release it
  task automatic send_item(input logic [1:0] op, input logic [NODE_W-1:0] node,
                           input logic [CHILD_W-1:0] l, input logic [CHILD_W-1:0] r,
                           input logic [BYTE_W-1:0] code);
    in_valid <= 1'b1;
    opcode <= op;
    node_index <= node;
    left_index <= l;
    right_index <= r;
    code_byte <= code;
    do @(posedge clk); while (!in_ready);
    sb.note_input(op, node, l, r, code);
    if (idle_on && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic send_load(input int node, input int l, input int r);
    if (node < NODE_COUNT && !written[node]) begin
      written[node] = 1'b1;
      written_q.push_back(node);
    end
    send_item(OP_LOAD, NODE_W'(node), CHILD_W'(l), CHILD_W'(r),
              BYTE_W'($urandom_range(0, 255)));
  endtask

  task automatic send_decode(input int code);
    send_item(OP_DECODE, NODE_W'($urandom_range(0, 511)), CHILD_W'($urandom),
              CHILD_W'($urandom), BYTE_W'(code));
  endtask

  task automatic send_restart();
    send_item(OP_RESTART, NODE_W'($urandom_range(0, 511)), CHILD_W'($urandom),
              CHILD_W'($urandom), BYTE_W'($urandom_range(0, 255)));
  endtask

  // block is idle once all symbols are out and the last byte walk has finished
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int rand_child();
    if ($urandom_range(0, 9) == 0 || written_q.size() == 0) return -1;
    return written_q[$urandom_range(0, written_q.size() - 1)];
  endfunction

  // random full binary tree, internal nodes counting down from base
  task automatic build_tree(input int n_leaves, input int base, output logic [NODE_W-1:0] root_id);
    int pool[$];
    bit used [512];
    int leaf;
    int ia;
    int a;
    int b;
    int next_id;
    while (pool.size() < n_leaves) begin
      leaf = ($urandom_range(0, 9) == 0) ? $urandom_range(256, 440) : $urandom_range(0, 255);
      if (!used[leaf]) begin
        used[leaf] = 1'b1;
        pool.push_back(leaf);
        send_load(leaf, -1, -1);
      end
    end
    next_id = base;
    while (pool.size() > 1) begin
      ia = $urandom_range(0, pool.size() - 1);
      a = pool[ia];
      pool.delete(ia);
      ia = $urandom_range(0, pool.size() - 1);
      b = pool[ia];
      pool.delete(ia);
      if ($urandom_range(0, 1)) send_load(next_id, a, b);
      else send_load(next_id, b, a);
      pool.push_back(next_id);
      next_id--;
    end
    root_id = NODE_W'(pool[0]);
  endtask

  initial begin
    logic [NODE_W-1:0] root_id;
    logic [TOTAL_W-1:0] total;
    int counted;
    int pick;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // leaves of the directed tree, and a root that starts as a leaf
    send_load(510, -1, -1);
    send_load(65, -1, -1);
    send_load(300, -1, -1);
    send_load(0, -1, -1);
    send_load(255, -1, -1);

    // total of zero: stream has ended from the start
    send_decode(8'hFF);
    write_reg(REG_TOTAL, 32'hFFFF_FFFF);
    // root is itself a leaf: never taken as a leaf
    send_decode(8'hA5);

    // codes: 0 -> 65, 10 -> 300 (wide leaf), 110 -> 0, 111 -> 255
    send_load(510, 65, 509);
    send_load(509, 300, 508);
    send_load(508, 0, 255);
    send_decode(8'h00);
    send_decode(8'hFF);
    send_decode(8'h4D);
    send_restart();
    send_decode(8'h00);
    send_load(511, 12, 34);
    send_item(OP_UNUSED, 9'd508, -10'sd1, -10'sd1, 8'h00);
    send_decode(8'hB6);

    // invalid children: none on the left, past the table on the right
    send_load(506, -1, 511);
    write_reg(REG_ROOT, 506);
    send_restart();
    send_decode(8'h00);
    send_decode(8'hFF);
    // cursor out of the table
    write_reg(REG_ROOT, 511);
    send_restart();
    send_decode(8'h3C);
    write_reg(REG_ROOT, 0);
    send_restart();
    send_decode(8'h00);

    // short stream ends mid byte
    write_reg(REG_ROOT, 510);
    write_reg(REG_TOTAL, 5);
    send_restart();
    send_decode(8'h00);
    send_decode(8'h00);
    send_restart();
    send_decode(8'hFF);

    // root change leaves the cursor where it is
    write_reg(REG_TOTAL, 32'hFFFF_FFFF);
    send_restart();
    send_decode(8'hFF);
    write_reg(REG_ROOT, 509);
    send_decode(8'h80);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase == PHASES - 1) idle_on = 1'b0;
      case (phase % 4)
        0: total = 32'hFFFF_FFFF;
        1: total = $urandom_range(10, 40);
        2: total = $urandom;
        default: total = $urandom_range(3, 12);
      endcase
      build_tree($urandom_range(2, 16), (phase % 2) ? 480 : 510, root_id);
      write_reg(REG_TOTAL, total);
      write_reg(REG_ROOT, root_id);
      if (phase % 3 != 1) send_restart();
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          send_decode($urandom_range(0, 255));
          counted++;
        end else if (pick < 88) begin
          send_restart();
          counted++;
        end else if (pick < 94) begin
          send_load($urandom_range(0, 510), rand_child(), rand_child());
          counted++;
        end else if (pick < 97) begin
          send_load(511, rand_child(), rand_child());
        end else begin
          send_item(OP_UNUSED, NODE_W'($urandom_range(0, 511)), CHILD_W'($urandom),
                    CHILD_W'($urandom), BYTE_W'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    if (sb.errors == 0 && sb.pending() == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
